[hdl/opm_pkg.sv]
// ----------------------------------------------------------------------------
// opm_pkg
// Shared constants and types for the overlapping pattern match counter.
// ----------------------------------------------------------------------------
package opm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int HIST_DEPTH  = PATTERN_MAX - 1;
  localparam int IDX_W       = $clog2(PATTERN_MAX);
  localparam int LEN_W       = IDX_W + 1;
  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 16;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int PAT_REGS    = 4;
  localparam int PAT_W       = PAT_REGS * CFG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEN      = 3'd0,
    CFG_PAT_LO   = 3'd1,
    CFG_PAT_MLO  = 3'd2,
    CFG_PAT_MHI  = 3'd3,
    CFG_PAT_HI   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

[hdl/opm_cell.sv]
// ----------------------------------------------------------------------------
// opm_cell
// One history position: holds a past text byte and its valid flag, shifts
// them on to the next cell and checks the byte against its pattern byte.
// ----------------------------------------------------------------------------
module opm_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  opm_pkg::cell_ctl_t          ctl,
  input  logic [opm_pkg::BYTE_W-1:0]  byte_in,
  input  logic                        valid_in,
  input  logic [opm_pkg::BYTE_W-1:0]  expect_byte,
  input  logic                        need,
  output logic [opm_pkg::BYTE_W-1:0]  byte_out,
  output logic                        valid_out,
  output logic                        ok
);

  logic [opm_pkg::BYTE_W-1:0] byte_r;
  logic                       valid_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_r <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= ctl.clear ? 1'b0 : valid_in;
    end
  end

  assign byte_out  = byte_r;
  assign valid_out = valid_r;
  assign ok        = !need || (valid_r && (byte_r == expect_byte));

endmodule

[hdl/overlapping_pattern_match_counter.sv]
// ----------------------------------------------------------------------------
// overlapping_pattern_match_counter
// Counts every occurrence, overlaps included, of a pattern of 1 to 32 bytes
// in a byte stream, one text byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid/in_ready carries in_text_byte and in_last_byte
//   output channel out_valid/out_ready carries out_match_ends_here,
//   out_match_count and out_text_done, one result word per input word
//   config port    cfg_we/cfg_index/cfg_wdata writes pattern_length (0) and
//   the four pattern byte registers (1 to 4), lowest byte first
// Each accepted word is registered in the output register and presented on the
// out_ ports. Throughput is one word per cycle while the receiver takes results;
// the rate is set by the row of 31 history cells, which all compare in parallel
// and shift once per accepted word.
// A word marked last returns the final count with out_text_done set, and
// the history and count are cleared behind it.
// When the receiver stalls, the result holds in the output register and
// in_ready drops until it is taken.
// Reset clears history, count and output valid; pattern_length returns to
// 1 and all pattern bytes to zero.
// ----------------------------------------------------------------------------
module overlapping_pattern_match_counter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [opm_pkg::BYTE_W-1:0]    in_text_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_match_ends_here,
  output logic [opm_pkg::COUNT_W-1:0]   out_match_count,
  output logic                          out_text_done,
  input  logic                          cfg_we,
  input  logic [opm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [opm_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int HD = opm_pkg::HIST_DEPTH;

  logic [opm_pkg::LEN_W-1:0]   len_r;
  logic [opm_pkg::CFG_W-1:0]   pat_r [opm_pkg::PAT_REGS];
  logic [opm_pkg::PAT_W-1:0]   pat_vec;
  logic [opm_pkg::LEN_W-1:0]   len_eff;
  logic [opm_pkg::IDX_W-1:0]   tail_idx;
  logic                        tail_eq;

  logic [opm_pkg::BYTE_W-1:0]  cell_byte [HD];
  logic [HD-1:0]               cell_valid;
  logic [HD-1:0]               cell_ok;
  opm_pkg::cell_ctl_t          ctl;

  logic                        accept;
  logic                        hit;
  logic [opm_pkg::COUNT_W-1:0] count_r;
  logic [opm_pkg::COUNT_W-1:0] count_nxt;

  logic                        out_valid_r;
  logic                        out_hit_r;
  logic [opm_pkg::COUNT_W-1:0] out_count_r;
  logic                        out_done_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= opm_pkg::LEN_W'(1);
      for (int i = 0; i < opm_pkg::PAT_REGS; i++) begin
        pat_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (opm_pkg::cfg_idx_t'(cfg_index))
        opm_pkg::CFG_LEN:     len_r    <= cfg_wdata[opm_pkg::LEN_W-1:0];
        opm_pkg::CFG_PAT_LO:  pat_r[0] <= cfg_wdata;
        opm_pkg::CFG_PAT_MLO: pat_r[1] <= cfg_wdata;
        opm_pkg::CFG_PAT_MHI: pat_r[2] <= cfg_wdata;
        opm_pkg::CFG_PAT_HI:  pat_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign pat_vec = {pat_r[3], pat_r[2], pat_r[1], pat_r[0]};
  assign len_eff = (len_r > opm_pkg::LEN_W'(opm_pkg::PATTERN_MAX)) ?
                   opm_pkg::LEN_W'(opm_pkg::PATTERN_MAX) : len_r;
  assign tail_idx = opm_pkg::IDX_W'(len_eff - opm_pkg::LEN_W'(1));
  assign tail_eq  = in_text_byte == pat_vec[{tail_idx, 3'b000} +: opm_pkg::BYTE_W];

  assign accept    = in_valid && in_ready;
  assign ctl.shift = accept;
  assign ctl.clear = in_last_byte;

  // history row, newest byte in cell 0
  for (genvar k = 0; k < HD; k++) begin : g_cell
    logic [opm_pkg::IDX_W-1:0]  idx;
    logic [opm_pkg::BYTE_W-1:0] byte_in;
    logic                       valid_in;
    logic                       need;

    assign need = opm_pkg::LEN_W'(k + 1) < len_eff;
    assign idx  = opm_pkg::IDX_W'(len_eff - opm_pkg::LEN_W'(k + 2));

    if (k == 0) begin : g_head
      assign byte_in  = in_text_byte;
      assign valid_in = 1'b1;
    end else begin : g_body
      assign byte_in  = cell_byte[k-1];
      assign valid_in = cell_valid[k-1];
    end

    opm_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .byte_in     (byte_in),
      .valid_in    (valid_in),
      .expect_byte (pat_vec[{idx, 3'b000} +: opm_pkg::BYTE_W]),
      .need        (need),
      .byte_out    (cell_byte[k]),
      .valid_out   (cell_valid[k]),
      .ok          (cell_ok[k])
    );
  end

  assign hit = (len_eff != '0) && tail_eq && (&cell_ok);

  // saturating count
  assign count_nxt = (hit && (count_r != '1)) ? count_r + opm_pkg::COUNT_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= in_last_byte ? '0 : count_nxt;
    end
  end

  // output register
  assign in_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_hit_r   <= hit;
      out_count_r <= count_nxt;
      out_done_r  <= in_last_byte;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_match_ends_here = out_hit_r;
  assign out_match_count     = out_count_r;
  assign out_text_done       = out_done_r;

endmodule
